// ===== rtl/npu_tdr_pkg.sv =====
// Shared types, register codes and constants for the task dispatch register block.
package npu_tdr_pkg;

   // Field widths
   localparam int DATA_W      = 64;
   localparam int CODE_W      = 32;
   localparam int IDX_W       = 5;
   localparam int CORE_W      = 3;
   localparam int SLOT_W      = 3;
   localparam int ARG_COUNT   = 8;
   localparam int STACK_SHIFT = 14;   // one stack is 0x4000 bytes
   localparam int MAX_CORES   = 8;

   localparam int DEFAULT_NPU_CORES = 4;

   // Operation kinds
   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_FINISH = 2'd2,
      OP_RSVD   = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNMAPPED  = 2'd1,
      ST_BUSY      = 2'd2,
      ST_IDLE_EXIT = 2'd3
   } status_type;

   // Register map
   localparam logic [IDX_W-1:0] REG_STATUS = 5'd0;
   localparam logic [IDX_W-1:0] REG_START  = 5'd1;
   localparam logic [IDX_W-1:0] REG_PC     = 5'd2;

   // One result word
   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   read_data;
      logic                launch_valid;
      logic [CORE_W-1:0]   launch_core;
      logic [DATA_W-1:0]   launch_pc;
      logic [DATA_W-1:0]   launch_sp;
      logic [DATA_W-1:0]   launch_tp;
      logic [SLOT_W-1:0]   arg_slot;
      logic [DATA_W-1:0]   arg_value;
      logic                last;
   } rsp_word_type;

   // Decoded outcome of one request word
   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   read_data;
      logic                start_go;
   } decode_type;

endpackage

// ===== rtl/npu_task_dispatch_regs_unit.sv =====
// Top level of the task dispatch register block: handshakes and result register.
// A request word is answered in the cycle after acceptance (result register); the
//   first launch word of a start passes the active flag, then the result register.
// Throughput: one request word per cycle while the result channel is not stalled; a
//   launching start emits NPU_CORES*8 launch words, one per cycle while not stalled.
// Requests are held off while the launch burst runs.
// Reset (synchronous): busy bitmap, exit codes, pc, arguments and stack end cleared.
module npu_task_dispatch_regs_unit #(
   parameter int NPU_CORES = npu_tdr_pkg::DEFAULT_NPU_CORES
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // operation
   input  logic [103:0]  req_tdata,   // reg_index, write_data, finish_core, finish_code
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic          rsp_tuser,   // launch_valid
   output logic          rsp_tlast,   // last
   output logic [327:0]  rsp_tdata,   // status, read_data, launch_core, launch_pc,
                                      // launch_sp, launch_tp, arg_slot, arg_value
   // configuration
   input  logic          csr_wr_en,
   input  logic [63:0]   csr_wr_data
);

   npu_tdr_pkg::decode_type           decode;
   npu_tdr_pkg::rsp_word_type         launch;
   npu_tdr_pkg::rsp_word_type         plain;
   npu_tdr_pkg::rsp_word_type         out_ff, out_in;
   logic                              out_valid_ff, out_valid_in;
   logic [npu_tdr_pkg::DATA_W-1:0]    task_pc;
   logic [npu_tdr_pkg::DATA_W-1:0]    arg_value;
   logic [npu_tdr_pkg::SLOT_W-1:0]    arg_slot;
   logic                              burst_active;
   logic                              out_free;
   logic                              req_take;
   logic                              load_plain;
   logic                              advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !burst_active && out_free;
   assign req_take   = req_tvalid && req_tready;
   assign load_plain = req_take && !decode.start_go;
   assign advance    = burst_active && out_free;

   npu_tdr_regs #(
      .NPU_CORES (NPU_CORES)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .item_take   (req_take),
      .operation   (npu_tdr_pkg::op_type'(req_tuser)),
      .reg_index   (req_tdata[4:0]),
      .write_data  (req_tdata[68:5]),
      .finish_core (req_tdata[71:69]),
      .finish_code (req_tdata[103:72]),
      .arg_slot    (arg_slot),
      .decode      (decode),
      .task_pc     (task_pc),
      .arg_value   (arg_value)
   );

   npu_tdr_launch #(
      .NPU_CORES (NPU_CORES)
   ) u_launch (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .start_go    (req_take && decode.start_go),
      .advance     (advance),
      .task_pc     (task_pc),
      .arg_value   (arg_value),
      .active      (burst_active),
      .arg_slot    (arg_slot),
      .launch      (launch)
   );

   // Single result word for everything but a launching start
   always_comb begin
      plain           = '0;
      plain.status    = decode.status;
      plain.read_data = decode.read_data;
      plain.last      = 1'b1;
   end

   // Result register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      priority if (load_plain) begin
         out_in       = plain;
         out_valid_in = 1'b1;
      end else if (advance) begin
         out_in       = launch;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.launch_valid;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {out_ff.arg_value, out_ff.arg_slot, out_ff.launch_tp,
                        out_ff.launch_sp, out_ff.launch_pc, out_ff.launch_core,
                        out_ff.read_data, out_ff.status};

endmodule

// ===== rtl/npu_tdr_regs.sv =====
// Task state registers (pc, arguments, busy bitmap, exit codes) and request decode.
module npu_tdr_regs #(
   parameter int NPU_CORES = npu_tdr_pkg::DEFAULT_NPU_CORES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 item_take,
   input  npu_tdr_pkg::op_type                  operation,
   input  logic [npu_tdr_pkg::IDX_W-1:0]        reg_index,
   input  logic [npu_tdr_pkg::DATA_W-1:0]       write_data,
   input  logic [npu_tdr_pkg::CORE_W-1:0]       finish_core,
   input  logic [npu_tdr_pkg::CODE_W-1:0]       finish_code,
   input  logic [npu_tdr_pkg::SLOT_W-1:0]       arg_slot,
   output npu_tdr_pkg::decode_type              decode,
   output logic [npu_tdr_pkg::DATA_W-1:0]       task_pc,
   output logic [npu_tdr_pkg::DATA_W-1:0]       arg_value
);

   localparam int CIW = (NPU_CORES > 1) ? $clog2(NPU_CORES) : 1;

   logic [NPU_CORES-1:0]              busy_ff, busy_in;
   logic [npu_tdr_pkg::CODE_W-1:0]    exit_ff [NPU_CORES];
   logic [npu_tdr_pkg::CODE_W-1:0]    exit_in [NPU_CORES];
   logic [npu_tdr_pkg::DATA_W-1:0]    pc_ff, pc_in;
   logic [npu_tdr_pkg::DATA_W-1:0]    args_ff [npu_tdr_pkg::ARG_COUNT];
   logic [npu_tdr_pkg::DATA_W-1:0]    args_in [npu_tdr_pkg::ARG_COUNT];

   logic             exit_hit;
   logic             arg_hit;
   logic             fin_hit;
   logic [CIW-1:0]   exit_idx;
   logic [CIW-1:0]   fin_idx;

   // Address decode
   assign exit_hit = reg_index[4] && ({1'b0, reg_index[3:0]} < 5'(NPU_CORES));
   assign arg_hit  = (reg_index[4:3] == 2'b01);
   assign fin_hit  = ({1'b0, finish_core} < 4'(NPU_CORES));
   assign exit_idx = reg_index[CIW-1:0];
   assign fin_idx  = finish_core[CIW-1:0];

   // Status and read data for the word
   always_comb begin
      decode.status    = npu_tdr_pkg::ST_UNMAPPED;
      decode.read_data = '0;
      decode.start_go  = 1'b0;
      unique case (operation)
         npu_tdr_pkg::OP_READ: begin
            if (reg_index == npu_tdr_pkg::REG_STATUS) begin
               decode.status    = npu_tdr_pkg::ST_OK;
               decode.read_data = npu_tdr_pkg::DATA_W'(busy_ff);
            end else if (exit_hit) begin
               decode.status    = npu_tdr_pkg::ST_OK;
               decode.read_data = npu_tdr_pkg::DATA_W'(exit_ff[exit_idx]);
            end
         end
         npu_tdr_pkg::OP_WRITE: begin
            if (reg_index == npu_tdr_pkg::REG_START) begin
               if (busy_ff != '0) begin
                  decode.status = npu_tdr_pkg::ST_BUSY;
               end else begin
                  decode.status   = npu_tdr_pkg::ST_OK;
                  decode.start_go = 1'b1;
               end
            end else if (exit_hit) begin
               decode.status = busy_ff[exit_idx] ? npu_tdr_pkg::ST_OK
                                                 : npu_tdr_pkg::ST_IDLE_EXIT;
            end else if (reg_index == npu_tdr_pkg::REG_PC || arg_hit) begin
               decode.status = npu_tdr_pkg::ST_OK;
            end
         end
         npu_tdr_pkg::OP_FINISH: decode.status = npu_tdr_pkg::ST_OK;
         default:                decode.status = npu_tdr_pkg::ST_UNMAPPED;
      endcase
   end

   // Next state
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      exit_in = exit_ff;
      args_in = args_ff;
      if (item_take) begin
         if (decode.start_go) begin
            busy_in = '1;
            for (int c = 0; c < NPU_CORES; c++) begin
               exit_in[c] = '0;
            end
         end
         if (operation == npu_tdr_pkg::OP_WRITE) begin
            if (reg_index == npu_tdr_pkg::REG_PC) begin
               pc_in = write_data;
            end
            if (arg_hit) begin
               args_in[reg_index[2:0]] = write_data;
            end
         end
         if (operation == npu_tdr_pkg::OP_FINISH && fin_hit) begin
            busy_in[fin_idx] = 1'b0;
            exit_in[fin_idx] = finish_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         pc_ff   <= '0;
         for (int c = 0; c < NPU_CORES; c++) begin
            exit_ff[c] <= '0;
         end
         for (int a = 0; a < npu_tdr_pkg::ARG_COUNT; a++) begin
            args_ff[a] <= '0;
         end
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         exit_ff <= exit_in;
         args_ff <= args_in;
      end
   end

   assign task_pc   = pc_ff;
   assign arg_value = args_ff[arg_slot];

endmodule

// ===== rtl/npu_tdr_launch.sv =====
// Launch burst sequencer: steps through cores and argument slots, builds launch words.
module npu_tdr_launch #(
   parameter int NPU_CORES = npu_tdr_pkg::DEFAULT_NPU_CORES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [npu_tdr_pkg::DATA_W-1:0]       csr_wr_data,
   input  logic                                 start_go,
   input  logic                                 advance,
   input  logic [npu_tdr_pkg::DATA_W-1:0]       task_pc,
   input  logic [npu_tdr_pkg::DATA_W-1:0]       arg_value,
   output logic                                 active,
   output logic [npu_tdr_pkg::SLOT_W-1:0]       arg_slot,
   output npu_tdr_pkg::rsp_word_type            launch
);

   localparam int CIW = (NPU_CORES > 1) ? $clog2(NPU_CORES) : 1;
   localparam logic [CIW-1:0] LAST_CORE = CIW'(NPU_CORES - 1);
   localparam logic [npu_tdr_pkg::SLOT_W-1:0] LAST_SLOT =
      npu_tdr_pkg::SLOT_W'(npu_tdr_pkg::ARG_COUNT - 1);

   logic [npu_tdr_pkg::DATA_W-1:0]  stack_end_ff;
   logic                            active_ff, active_in;
   logic [CIW-1:0]                  core_ff, core_in;
   logic [npu_tdr_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic                            last_word;
   logic [npu_tdr_pkg::DATA_W-1:0]  sp_off, tp_off;

   // Stack end register
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_end_ff <= '0;
      end else if (csr_wr_en) begin
         stack_end_ff <= csr_wr_data;
      end
   end

   assign last_word = (core_ff == LAST_CORE) && (slot_ff == LAST_SLOT);

   // Burst counter: slot minor, core major
   always_comb begin
      active_in = active_ff;
      core_in   = core_ff;
      slot_in   = slot_ff;
      priority if (start_go) begin
         active_in = 1'b1;
         core_in   = '0;
         slot_in   = '0;
      end else if (advance) begin
         if (last_word) begin
            active_in = 1'b0;
         end else if (slot_ff == LAST_SLOT) begin
            slot_in = '0;
            core_in = core_ff + 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         core_ff   <= '0;
         slot_ff   <= '0;
      end else begin
         active_ff <= active_in;
         core_ff   <= core_in;
         slot_ff   <= slot_in;
      end
   end

   // Stack and thread pointers, both taken straight off the stack end
   assign sp_off = npu_tdr_pkg::DATA_W'(core_ff) << npu_tdr_pkg::STACK_SHIFT;
   assign tp_off = (npu_tdr_pkg::DATA_W'(core_ff) + 1'b1) << npu_tdr_pkg::STACK_SHIFT;

   always_comb begin
      launch              = '0;
      launch.status       = npu_tdr_pkg::ST_OK;
      launch.launch_valid = 1'b1;
      launch.launch_core  = npu_tdr_pkg::CORE_W'(core_ff);
      launch.launch_pc    = task_pc;
      launch.launch_sp    = stack_end_ff - sp_off;
      launch.launch_tp    = stack_end_ff - tp_off;
      launch.arg_slot     = slot_ff;
      launch.arg_value    = arg_value;
      launch.last         = last_word;
   end

   assign active   = active_ff;
   assign arg_slot = slot_ff;

endmodule
